// ===== hdl/scr_pkg.sv =====
// Shared constants for the stepped current regulator: register map, reset values, item codes.
`timescale 1ns / 1ps
`default_nettype none
package scr_pkg;

    localparam int CNT_W   = 16;
    localparam int CUR_W   = 12;
    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 32;

    localparam int DAC_MAX_DEFAULT        = 4095;
    localparam int INITIAL_TARGET_DEFAULT = 500;

    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DOWN = 2'd2;

    localparam logic [2:0] REG_COMP_PERIOD = 3'd0;
    localparam logic [2:0] REG_LOCKOUT     = 3'd1;
    localparam logic [2:0] REG_TARGET_STEP = 3'd2;
    localparam logic [2:0] REG_TARGET_MAX  = 3'd3;
    localparam logic [2:0] REG_COARSE_THR  = 3'd4;
    localparam logic [2:0] REG_FINE_THR    = 3'd5;
    localparam logic [2:0] REG_COARSE_STEP = 3'd6;
    localparam logic [2:0] REG_FINE_STEP   = 3'd7;

    localparam logic [CNT_W-1:0] RST_COMP_PERIOD = 16'd100;
    localparam logic [CNT_W-1:0] RST_LOCKOUT     = 16'd200;
    localparam logic [CUR_W-1:0] RST_TARGET_STEP = 12'd100;
    localparam logic [CUR_W-1:0] RST_TARGET_MAX  = 12'd1000;
    localparam logic [CUR_W-1:0] RST_COARSE_THR  = 12'd20;
    localparam logic [CUR_W-1:0] RST_FINE_THR    = 12'd5;
    localparam logic [CUR_W-1:0] RST_COARSE_STEP = 12'd50;
    localparam logic [CUR_W-1:0] RST_FINE_STEP   = 12'd10;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage
`default_nettype wire

// ===== hdl/stepped_current_regulator_unit.sv =====
// Stepped current regulator: press lockout, target stepping and DAC compensation.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: func; tdata: measured_current
//  m_axis    out  m_axis_tvalid/tready       tdata: dac_code, dac_write, target, press
//  apb       in   psel/penable/pwrite/pready register writes and reads
//
//  One beat per cycle sustained while m_axis is ready; results leave via the result register.
//  The input register feeds one pass of update logic into the result register;
//  the state registers load at the same edge, so back-to-back beats see fresh state.
//  Reset is synchronous, active low; it restores register and state defaults.
//  A stalled m_axis holds the result; the input register holds one more beat.
`timescale 1ns / 1ps
`default_nettype none
module stepped_current_regulator_unit #(
    parameter int DAC_MAX        = scr_pkg::DAC_MAX_DEFAULT,
    parameter int INITIAL_TARGET = scr_pkg::INITIAL_TARGET_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // [11:0] measured_current, [15:12] zero
    input  wire logic [scr_pkg::IN_W-1:0]   s_axis_tdata,
    // [1:0] func
    input  wire logic [scr_pkg::FUNC_W-1:0] s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [11:0] dac_code, [12] dac_write, [24:13] target_current, [25] press_accepted,
    // [31:26] zero
    output logic [scr_pkg::OUT_W-1:0]       m_axis_tdata,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [scr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [scr_pkg::DATA_W-1:0] pwdata,
    output logic [scr_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import scr_pkg::*;

    localparam int CODE_W = $clog2(DAC_MAX + 1);
    localparam int EXT_W  = (CODE_W > CUR_W) ? CODE_W : CUR_W;
    localparam int SUM_W  = EXT_W + 1;

    logic [CNT_W-1:0]  r_comp_period;
    logic [CNT_W-1:0]  r_lockout;
    logic [CUR_W-1:0]  r_target_step;
    logic [CUR_W-1:0]  r_target_max;
    logic [CUR_W-1:0]  r_coarse_thr;
    logic [CUR_W-1:0]  r_fine_thr;
    logic [CUR_W-1:0]  r_coarse_step;
    logic [CUR_W-1:0]  r_fine_step;

    logic [CNT_W-1:0]  r_since_press,  n_since_press;
    logic [CNT_W-1:0]  r_since_comp,   n_since_comp;
    logic [CUR_W-1:0]  r_target,       n_target;
    logic [CODE_W-1:0] r_code,         n_code;

    logic              r_in_valid;
    logic [FUNC_W-1:0] r_in_func;
    logic [CUR_W-1:0]  r_in_meas;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data,     n_out_data;

    logic              adv;
    logic              wr;
    logic              acc;
    logic              cfg_wr;
    logic [2:0]        reg_idx;

    logic [CNT_W-1:0]  sp_inc;
    logic [CNT_W-1:0]  sc_inc;
    logic              raise;
    logic [CUR_W-1:0]  mag;
    logic              coarse;
    logic              fine;
    logic [CUR_W-1:0]  step;
    logic [EXT_W-1:0]  code_ext;
    logic [EXT_W-1:0]  new_ext;
    logic [SUM_W-1:0]  code_sum;
    logic [CUR_W:0]    tgt_sum;
    logic [CODE_W-1:0] moved;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        unique case (reg_idx)
            REG_COMP_PERIOD: prdata = DATA_W'(r_comp_period);
            REG_LOCKOUT:     prdata = DATA_W'(r_lockout);
            REG_TARGET_STEP: prdata = DATA_W'(r_target_step);
            REG_TARGET_MAX:  prdata = DATA_W'(r_target_max);
            REG_COARSE_THR:  prdata = DATA_W'(r_coarse_thr);
            REG_FINE_THR:    prdata = DATA_W'(r_fine_thr);
            REG_COARSE_STEP: prdata = DATA_W'(r_coarse_step);
            REG_FINE_STEP:   prdata = DATA_W'(r_fine_step);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_period <= RST_COMP_PERIOD;
            r_lockout     <= RST_LOCKOUT;
            r_target_step <= RST_TARGET_STEP;
            r_target_max  <= RST_TARGET_MAX;
            r_coarse_thr  <= RST_COARSE_THR;
            r_fine_thr    <= RST_FINE_THR;
            r_coarse_step <= RST_COARSE_STEP;
            r_fine_step   <= RST_FINE_STEP;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_COMP_PERIOD: r_comp_period <= pwdata[CNT_W-1:0];
                REG_LOCKOUT:     r_lockout     <= pwdata[CNT_W-1:0];
                REG_TARGET_STEP: r_target_step <= pwdata[CUR_W-1:0];
                REG_TARGET_MAX:  r_target_max  <= pwdata[CUR_W-1:0];
                REG_COARSE_THR:  r_coarse_thr  <= pwdata[CUR_W-1:0];
                REG_FINE_THR:    r_fine_thr    <= pwdata[CUR_W-1:0];
                REG_COARSE_STEP: r_coarse_step <= pwdata[CUR_W-1:0];
                REG_FINE_STEP:   r_fine_step   <= pwdata[CUR_W-1:0];
                default:         r_fine_step   <= r_fine_step;
            endcase
        end
    end

    always_comb begin
        sp_inc   = (r_since_press == CNT_MAX) ? CNT_MAX : r_since_press + 1'b1;
        sc_inc   = (r_since_comp == CNT_MAX) ? CNT_MAX : r_since_comp + 1'b1;
        raise    = r_target > r_in_meas;
        mag      = raise ? r_target - r_in_meas : r_in_meas - r_target;
        coarse   = mag > r_coarse_thr;
        fine     = mag > r_fine_thr;
        step     = coarse ? r_coarse_step : r_fine_step;
        code_ext = EXT_W'(r_code);
        code_sum = SUM_W'(code_ext) + SUM_W'(step);
        new_ext  = (code_ext > EXT_W'(step)) ? code_ext - EXT_W'(step) : '0;
        if (raise) begin
            moved = (code_sum > SUM_W'(DAC_MAX)) ? CODE_W'(DAC_MAX) : CODE_W'(code_sum);
        end else begin
            moved = CODE_W'(new_ext);
        end
        tgt_sum = {1'b0, r_target} + {1'b0, r_target_step};

        n_since_press = r_since_press;
        n_since_comp  = r_since_comp;
        n_target      = r_target;
        n_code        = r_code;
        wr            = 1'b0;
        acc           = 1'b0;

        unique case (r_in_func)
            FUNC_TICK: begin
                n_since_press = sp_inc;
                n_since_comp  = sc_inc;
                if (sc_inc >= r_comp_period) begin
                    n_since_comp = '0;
                    if (coarse || fine) begin
                        n_code = moved;
                        wr     = 1'b1;
                    end
                end
            end
            FUNC_UP: begin
                if (r_since_press > r_lockout) begin
                    acc           = 1'b1;
                    n_since_press = '0;
                    n_target      = (tgt_sum > {1'b0, r_target_max})
                                  ? r_target_max : tgt_sum[CUR_W-1:0];
                end
            end
            FUNC_DOWN: begin
                if (r_since_press > r_lockout) begin
                    acc           = 1'b1;
                    n_since_press = '0;
                    n_target      = (r_target > r_target_step)
                                  ? r_target - r_target_step : '0;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase

        n_out_data = {6'd0, acc, n_target, wr, CUR_W'(n_code)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_since_press <= '0;
            r_since_comp  <= '0;
            r_target      <= CUR_W'(INITIAL_TARGET);
            r_code        <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_since_press <= n_since_press;
                r_since_comp  <= n_since_comp;
                r_target      <= n_target;
                r_code        <= n_code;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= s_axis_tuser;
            r_in_meas <= s_axis_tdata[CUR_W-1:0];
        end
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[CUR_W] && r_out_data[2*CUR_W+1]))
        else $error("dac_write and press_accepted set in one result");

    a_press_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && acc) |=> (r_since_press == '0))
        else $error("accepted press did not clear the press counter");

    a_code_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_code) <= SUM_W'(DAC_MAX))
        else $error("drive code above limit");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_func) && $stable(r_in_meas)))
        else $error("stalled input beat lost");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_out_data[2*CUR_W:CUR_W+1] == r_target))
        else $error("result target differs from state");

endmodule
`default_nettype wire

// ===== dv/tb_stepped_current_regulator_unit.sv =====
// Self-checking testbench for the stepped current regulator: stream items in, results checked.
`timescale 1ns / 1ps
module tb_stepped_current_regulator_unit;
    import scr_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASES       = 14;
    localparam int CUR_MAX      = (1 << CUR_W) - 1;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // packed to match m_axis_tdata[25:0]
    typedef struct packed {
        logic             press;
        logic [CUR_W-1:0] target;
        logic             dac_write;
        logic [CUR_W-1:0] dac_code;
    } t_reg_beat;

    typedef struct {
        int unsigned period;
        int unsigned lockout;
        int unsigned tstep;
        int unsigned tmax;
        int unsigned cthr;
        int unsigned fthr;
        int unsigned cstep;
        int unsigned fstep;
    } t_cfg;

    class t_scr_scoreboard;
        logic [CNT_W-1:0] comp_period = RST_COMP_PERIOD;
        logic [CNT_W-1:0] lockout     = RST_LOCKOUT;
        logic [CUR_W-1:0] tgt_step    = RST_TARGET_STEP;
        logic [CUR_W-1:0] tgt_max     = RST_TARGET_MAX;
        logic [CUR_W-1:0] coarse_thr  = RST_COARSE_THR;
        logic [CUR_W-1:0] fine_thr    = RST_FINE_THR;
        logic [CUR_W-1:0] coarse_step = RST_COARSE_STEP;
        logic [CUR_W-1:0] fine_step   = RST_FINE_STEP;

        logic [CNT_W-1:0] since_press = '0;
        logic [CNT_W-1:0] since_comp  = '0;
        logic [CUR_W-1:0] target      = CUR_W'(INITIAL_TARGET_DEFAULT);
        logic [CUR_W-1:0] code        = '0;

        t_reg_beat expected_beats[$];
        int mismatches    = 0;
        int beats_checked = 0;
        int presses_taken = 0;
        int dac_steps     = 0;

        function void set_reg(logic [2:0] idx, int unsigned val);
            case (idx)
                REG_COMP_PERIOD: comp_period = val[CNT_W-1:0];
                REG_LOCKOUT:     lockout     = val[CNT_W-1:0];
                REG_TARGET_STEP: tgt_step    = val[CUR_W-1:0];
                REG_TARGET_MAX:  tgt_max     = val[CUR_W-1:0];
                REG_COARSE_THR:  coarse_thr  = val[CUR_W-1:0];
                REG_FINE_THR:    fine_thr    = val[CUR_W-1:0];
                REG_COARSE_STEP: coarse_step = val[CUR_W-1:0];
                REG_FINE_STEP:   fine_step   = val[CUR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
            return (c == CNT_MAX) ? c : c + 1'b1;
        endfunction

        function void slew(bit raise, logic [CUR_W-1:0] step);
            int sum;
            sum = int'(code) + int'(step);
            if (raise)
                code = (sum > DAC_MAX_DEFAULT) ? CUR_W'(DAC_MAX_DEFAULT) : sum[CUR_W-1:0];
            else
                code = (code > step) ? code - step : '0;
            dac_steps++;
        endfunction

        function void note_item(logic [FUNC_W-1:0] func, logic [CUR_W-1:0] meas);
            t_reg_beat r;
            bit raise;
            int mag;
            int sum;
            r = '0;
            if (func == FUNC_TICK) begin
                since_press = bump(since_press);
                since_comp  = bump(since_comp);
                if (since_comp >= comp_period) begin
                    raise = target > meas;
                    mag = raise ? int'(target) - int'(meas) : int'(meas) - int'(target);
                    since_comp = '0;
                    if (mag > int'(coarse_thr)) begin
                        slew(raise, coarse_step);
                        r.dac_write = 1'b1;
                    end else if (mag > int'(fine_thr)) begin
                        slew(raise, fine_step);
                        r.dac_write = 1'b1;
                    end
                end
            end else if (func == FUNC_UP || func == FUNC_DOWN) begin
                if (since_press > lockout) begin
                    r.press = 1'b1;
                    presses_taken++;
                    since_press = '0;
                    if (func == FUNC_UP) begin
                        sum = int'(target) + int'(tgt_step);
                        target = (sum > int'(tgt_max)) ? tgt_max : sum[CUR_W-1:0];
                    end else begin
                        target = (target > tgt_step) ? target - tgt_step : '0;
                    end
                end
            end
            r.dac_code = code;
            r.target   = target;
            expected_beats.push_back(r);
        endfunction

        function void check_beat(logic [OUT_W-1:0] data);
            t_reg_beat got;
            t_reg_beat want;
            got = data[$bits(t_reg_beat)-1:0];
            if (expected_beats.size() == 0) begin
                $error("result beat %h arrived with nothing expected", data);
                mismatches++;
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (got.dac_code !== want.dac_code) begin
                $error("dac_code: expected %0d, got %0d", want.dac_code, got.dac_code);
                mismatches++;
            end
            if (got.dac_write !== want.dac_write) begin
                $error("dac_write: expected %0d, got %0d", want.dac_write, got.dac_write);
                mismatches++;
            end
            if (got.target !== want.target) begin
                $error("target_current: expected %0d, got %0d", want.target, got.target);
                mismatches++;
            end
            if (got.press !== want.press) begin
                $error("press_accepted: expected %0d, got %0d", want.press, got.press);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [IN_W-1:0]   s_data  = '0;
    logic [FUNC_W-1:0] s_user  = FUNC_TICK;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [OUT_W-1:0]  m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    int cfg_loads   = 0;

    t_scr_scoreboard sb = new();

    stepped_current_regulator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),   // [11:0] measured_current, [15:12] zero
        .s_axis_tuser  (s_user),   // [1:0] func
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),   // [11:0] dac_code, [12] dac_write, [24:13] target,
                                   // [25] press_accepted, [31:26] zero
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [CUR_W-1:0] meas);
        int gap;
        gap = (idle_on && !hold_active && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= func;
        s_data  <= {{(IN_W-CUR_W){1'b0}}, meas};
        do @(posedge i_clk); while (!s_ready);
        sb.note_item(func, meas);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(REG_COMP_PERIOD, c.period);
        write_reg(REG_LOCKOUT,     c.lockout);
        write_reg(REG_TARGET_STEP, c.tstep);
        write_reg(REG_TARGET_MAX,  c.tmax);
        write_reg(REG_COARSE_THR,  c.cthr);
        write_reg(REG_FINE_THR,    c.fthr);
        write_reg(REG_COARSE_STEP, c.cstep);
        write_reg(REG_FINE_STEP,   c.fstep);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cfg_loads++;
    endtask

    function automatic int unsigned draw(int unsigned lo, int unsigned hi, int unsigned typ);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            default: return $urandom_range(typ, lo);
        endcase
    endfunction

    function automatic logic [CUR_W-1:0] pick_current();
        int v;
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            v = int'(sb.target) + int'($urandom_range(0, 80)) - 40;
        else if (r < 12)
            v = 0;
        else if (r < 14)
            v = CUR_MAX;
        else
            v = $urandom_range(0, CUR_MAX);
        if (v < 0) v = 0;
        if (v > CUR_MAX) v = CUR_MAX;
        return v[CUR_W-1:0];
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 66) return FUNC_TICK;
        if (r < 79) return FUNC_UP;
        if (r < 92) return FUNC_DOWN;
        return FUNC_UNUSED;
    endfunction

    // result sink: random stalls, plus one long hold-off on request
    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_active = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) sb.check_beat(m_data);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("stepped_current_regulator_unit verification failed");
        $finish;
    end

    initial begin
        t_cfg c;
        logic [FUNC_W-1:0] f;
        int counted;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: presses locked out, unused code ignored
        send_item(FUNC_UP, 12'd0);
        send_item(FUNC_DOWN, 12'd0);
        send_item(FUNC_UNUSED, 12'hFFF);
        send_item(FUNC_TICK, 12'd0);
        send_item(FUNC_TICK, 12'hFFF);
        settle();

        // zero period, zero lockout, full steps: saturation both ways
        c = '{0, 0, CUR_MAX, CUR_MAX, 0, 0, CUR_MAX, CUR_MAX};
        load_config(c);
        send_item(FUNC_TICK, 12'd0);
        send_item(FUNC_TICK, 12'd0);
        send_item(FUNC_UP, 12'd0);
        send_item(FUNC_UP, 12'd0);
        send_item(FUNC_TICK, 12'hFFF);
        send_item(FUNC_DOWN, 12'hFFF);
        send_item(FUNC_TICK, 12'hFFF);
        send_item(FUNC_TICK, 12'hFFF);
        send_item(FUNC_TICK, 12'd0);
        settle();

        // coarse threshold below fine threshold: coarse test wins
        c = '{1, 0, 3000, CUR_MAX, 2, 100, 7, 1};
        load_config(c);
        send_item(FUNC_UP, 12'd0);
        send_item(FUNC_TICK, 12'd2997);
        send_item(FUNC_TICK, 12'd3001);
        send_item(FUNC_TICK, 12'd2999);
        settle();

        // lowered maximum pulls the target down on an up press
        c = '{65535, 3, 3000, 0, 2, 100, 7, 1};
        load_config(c);
        send_item(FUNC_TICK, 12'd0);
        send_item(FUNC_TICK, 12'd0);
        send_item(FUNC_TICK, 12'd0);
        send_item(FUNC_UP, 12'd0);
        send_item(FUNC_TICK, 12'd0);
        send_item(FUNC_UP, 12'd0);
        send_item(FUNC_UNUSED, 12'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            c.period  = draw(0, 65535, 12);
            c.lockout = draw(0, 65535, 15);
            c.tstep   = draw(0, CUR_MAX, 300);
            c.tmax    = draw(0, CUR_MAX, CUR_MAX);
            c.cthr    = draw(0, CUR_MAX, 60);
            c.fthr    = draw(0, CUR_MAX, 30);
            c.cstep   = draw(0, CUR_MAX, 300);
            c.fstep   = draw(0, CUR_MAX, 60);
            load_config(c);
            if (ph >= PHASES - 2) idle_on = 1'b0;
            if (ph == 2) hold_req = 1'b1;
            counted = 0;
            while (counted < RANDOM_ITEMS / PHASES) begin
                f = pick_func();
                send_item(f, pick_current());
                counted++;
            end
        end
        settle();

        $display("Checked %0d result beats over %0d register loads.", sb.beats_checked, cfg_loads);
        $display("Presses taken: %0d, DAC steps: %0d.", sb.presses_taken, sb.dac_steps);
        if (sb.mismatches == 0)
            $display("stepped_current_regulator_unit verification clean");
        else
            $display("stepped_current_regulator_unit verification failed");
        $finish;
    end
endmodule

// ===== stepped_current_regulator_unit.f =====
hdl/scr_pkg.sv
hdl/stepped_current_regulator_unit.sv
dv/tb_stepped_current_regulator_unit.sv
